[rtl/krq_pkg.sv]
// Shared constants, types and command/status structs for the keyed ring queue.
package krq_pkg;

   localparam int DEPTH = 128;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int KEY_W = 64;
   localparam int DAY_W = 32;
   localparam int AMT_W = 16;
   localparam int TKT_W = 32;
   localparam int TOTAL_W = 24;
   localparam int OCC_W = 8;
   localparam int ACT_W = 3;
   localparam int STAT_W = 2;
   localparam int REQ_DATA_W = KEY_W + DAY_W + AMT_W + TKT_W;
   localparam int RSP_DATA_W = KEY_W + DAY_W + AMT_W + TKT_W + TOTAL_W + OCC_W;

   typedef enum logic [ACT_W-1:0] {
      ACT_APPEND  = 3'd0,
      ACT_DROP    = 3'd1,
      ACT_READ    = 3'd2,
      ACT_FIND    = 3'd3,
      ACT_SUM_DAY = 3'd4,
      ACT_SUM_ALL = 3'd5
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [DAY_W-1:0] day;
      logic [AMT_W-1:0] amount;
      logic [TKT_W-1:0] ticket;
   } record_type;

   // Controller to datapath.
   typedef struct packed {
      logic start;
      logic scan;
      logic finish;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic scan_done;
      logic out_free;
   } stat_type;

endpackage

[rtl/krq_ctrl.sv]
// Controller state machine: accept, scan the stored records, then commit and respond.
module krq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  krq_pkg::stat_type stat,
   output krq_pkg::cmd_type  cmd
);
   import krq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign cmd.start  = (state_ff == ST_IDLE) && req_tvalid;
   assign cmd.scan   = (state_ff == ST_SCAN);
   assign cmd.finish = (state_ff == ST_FINISH) && stat.out_free;

endmodule

[rtl/krq_dpath.sv]
// Datapath: record memory, ring pointers, scan pipeline, accumulators and result register.
module krq_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  krq_pkg::cmd_type                cmd,
   output krq_pkg::stat_type               stat,
   input  logic [krq_pkg::ACT_W-1:0]       req_action,
   input  krq_pkg::record_type             req_rec,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [krq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [krq_pkg::STAT_W-1:0]      rsp_tuser
);
   import krq_pkg::*;

   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   record_type mem [DEPTH];
   record_type rd_data_ff;
   record_type req_ff;
   record_type hit_rec_ff, hit_rec_in;
   logic [ACT_W-1:0]   act_ff;
   logic [PTR_W-1:0]   head_ff, head_in, tail_ff, tail_in, scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]   fill_ff, fill_in, left_ff, left_in;
   logic               pend_ff, pend_in, hit_ff, hit_in, rd_en, mem_we;
   logic [TOTAL_W-1:0] sum_ff, sum_in;
   logic [TOTAL_W:0]   sum_add;
   logic               match_any, is_find, is_sum, rec_match, day_match;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0]  rsp_user_ff, rsp_user_in;
   status_type         st;
   record_type         out_rec;
   logic [TOTAL_W-1:0] out_total;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      next_slot = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
   endfunction

   assign is_find   = (act_ff == ACT_FIND);
   assign match_any = (act_ff == ACT_READ);
   assign is_sum    = (act_ff == ACT_SUM_DAY) || (act_ff == ACT_SUM_ALL);
   assign rec_match = pend_ff && !hit_ff &&
                      (match_any || (is_find && rd_data_ff.key == req_ff.key));
   assign day_match = (act_ff == ACT_SUM_ALL) || (rd_data_ff.day == req_ff.day);
   assign sum_add   = {1'b0, sum_ff} + (TOTAL_W + 1)'(rd_data_ff.amount);

   // A search stops issuing reads once it has a hit; reads still in flight are ignored.
   assign rd_en  = cmd.scan && (left_ff != '0) && !hit_ff;
   assign mem_we = cmd.finish && (act_ff == ACT_APPEND) && (fill_ff != FULL_CNT);

   assign stat.scan_done = !pend_ff && ((left_ff == '0) || hit_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      scan_idx_in = scan_idx_ff;
      left_in     = left_ff;
      pend_in     = 1'b0;
      hit_in      = hit_ff;
      hit_rec_in  = hit_rec_ff;
      sum_in      = sum_ff;
      if (cmd.start) begin
         scan_idx_in = head_ff;
         hit_in      = 1'b0;
         sum_in      = '0;
         case (req_action)
            ACT_READ:                         left_in = (fill_ff != '0) ? CNT_W'(1) : '0;
            ACT_FIND, ACT_SUM_DAY, ACT_SUM_ALL: left_in = fill_ff;
            default:                          left_in = '0;
         endcase
      end else begin
         if (rd_en) begin
            scan_idx_in = next_slot(scan_idx_ff);
            left_in     = left_ff - CNT_W'(1);
            pend_in     = 1'b1;
         end
         if (rec_match) begin
            hit_in     = 1'b1;
            hit_rec_in = rd_data_ff;
         end
         if (pend_ff && is_sum && day_match) begin
            sum_in = sum_add[TOTAL_W] ? '1 : sum_add[TOTAL_W-1:0];
         end
      end
   end

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      fill_in   = fill_ff;
      st        = STAT_OK;
      out_rec   = '0;
      out_total = '0;
      case (act_ff)
         ACT_APPEND: begin
            if (fill_ff == FULL_CNT) begin
               st = STAT_FULL;
            end else begin
               tail_in = next_slot(tail_ff);
               fill_in = fill_ff + CNT_W'(1);
            end
         end
         ACT_DROP: begin
            if (fill_ff == '0) begin
               st = STAT_EMPTY;
            end else begin
               head_in = next_slot(head_ff);
               fill_in = fill_ff - CNT_W'(1);
            end
         end
         ACT_READ, ACT_FIND: begin
            if (hit_ff) out_rec = hit_rec_ff;
            else        st      = STAT_EMPTY;
         end
         ACT_SUM_DAY, ACT_SUM_ALL: out_total = sum_ff;
         default: ;
      endcase
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {OCC_W'(fill_in), out_total, out_rec.ticket, out_rec.amount,
                         out_rec.day, out_rec.key};
         rsp_user_in  = st;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[tail_ff] <= req_ff;
      if (rd_en)  rd_data_ff   <= mem[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
            fill_ff <= fill_in;
         end
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_ff <= req_rec;
         act_ff <= req_action;
      end
      scan_idx_ff <= scan_idx_in;
      hit_rec_ff  <= hit_rec_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[rtl/keyed_ring_queue.sv]
// Top level of the keyed ring queue: controller plus datapath.
//
// A queue of up to 128 records (key, day, amount, ticket) in a ring buffer held in
// a single-port-write, single-port-read memory. One transaction is processed at a
// time. Every action passes through the idle, scan and finish states before the
// result register is loaded. Append, drop, the unused action codes and any action
// on an empty queue read no records, and read fetches only the oldest one. Find,
// sum by date and sum all walk the stored records from the oldest one, one memory
// read per cycle; find stops issuing reads at the first match. The block returns
// to idle before the next transaction is accepted. A new request is accepted while
// an earlier result still waits in the output register. The block then holds in
// its last step until that result is taken. No clearing pass is needed after reset.
module keyed_ring_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata, lowest bit up: vehicle_key[63:0], day_code[31:0], amount[15:0], ticket[31:0]
   input  logic [krq_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: action[2:0]
   input  logic [krq_pkg::ACT_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata, lowest bit up: found_key[63:0], found_day[31:0], found_amount[15:0],
   // found_ticket[31:0], total[23:0], occupancy[7:0]
   output logic [krq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // tuser: status[1:0]
   output logic [krq_pkg::STAT_W-1:0]      rsp_tuser
);
   import krq_pkg::*;

   cmd_type    cmd;
   stat_type   stat;
   record_type req_rec;

   assign req_rec.key    = req_tdata[KEY_W-1:0];
   assign req_rec.day    = req_tdata[KEY_W +: DAY_W];
   assign req_rec.amount = req_tdata[KEY_W+DAY_W +: AMT_W];
   assign req_rec.ticket = req_tdata[KEY_W+DAY_W+AMT_W +: TKT_W];

   krq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   krq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_action (req_tuser),
      .req_rec    (req_rec),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[verif/keyed_ring_queue_tb.sv]
// Self-checking testbench for the keyed ring queue: random and directed actions, scoreboard.
module keyed_ring_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import krq_pkg::*;

   // Action codes the block treats as no-ops.
   localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

   localparam int SEG_FILL  = 0;
   localparam int SEG_MIXED = 1;
   localparam int SEG_DRAIN = 2;

   localparam int RANDOM_ITEMS  = 1700;
   localparam int SEG_LEN       = 100;
   localparam int TAIL_CYCLES   = 150;
   localparam int WATCHDOG_MAX  = 4000;
   localparam int HOLD_AT_COUNT = 400;
   localparam int HOLD_CYCLES   = 600;

   typedef struct {
      logic [ACT_W-1:0] action;
      record_type       rec;
   } toll_req_type;

   typedef struct {
      status_type         status;
      record_type         rec;
      logic [TOTAL_W-1:0] total;
      logic [OCC_W-1:0]   occupancy;
   } toll_reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [ACT_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;

   keyed_ring_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Pending requests, and replies predicted for accepted requests.
   toll_req_type   pending_reqs[$];
   toll_reply_type expected_replies[$];

   // Shadow copy of the ring.
   record_type  ring_store[DEPTH];
   int unsigned ring_head = 0;
   int unsigned ring_tail = 0;
   int unsigned fill_level = 0;

   logic [KEY_W-1:0] key_pool[16];
   logic [DAY_W-1:0] day_pool[8];

   int error_count = 0;
   int sent_count = 0;
   int got_count = 0;
   int idle_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic int unsigned ring_next(input int unsigned p);
      return (p + 1 >= DEPTH) ? 0 : p + 1;
   endfunction

   // Applies one action to the shadow ring and returns the reply it must produce.
   function automatic toll_reply_type predict_reply(input toll_req_type r);
      toll_reply_type y;
      int unsigned idx;
      int unsigned sum;
      y.status = STAT_OK;
      y.rec = '0;
      y.total = '0;
      sum = 0;
      case (r.action)
         ACT_APPEND: begin
            if (fill_level >= DEPTH) begin
               y.status = STAT_FULL;
            end else begin
               ring_store[ring_tail] = r.rec;
               ring_tail = ring_next(ring_tail);
               fill_level++;
            end
         end
         ACT_DROP: begin
            if (fill_level == 0) begin
               y.status = STAT_EMPTY;
            end else begin
               ring_head = ring_next(ring_head);
               fill_level--;
            end
         end
         ACT_READ: begin
            if (fill_level == 0) y.status = STAT_EMPTY;
            else y.rec = ring_store[ring_head];
         end
         ACT_FIND: begin
            y.status = STAT_EMPTY;
            idx = ring_head;
            for (int i = 0; i < fill_level; i++) begin
               if (ring_store[idx].key == r.rec.key) begin
                  y.status = STAT_OK;
                  y.rec = ring_store[idx];
                  break;
               end
               idx = ring_next(idx);
            end
         end
         ACT_SUM_DAY, ACT_SUM_ALL: begin
            idx = ring_head;
            for (int i = 0; i < fill_level; i++) begin
               if (r.action == ACT_SUM_ALL || ring_store[idx].day == r.rec.day) begin
                  sum += ring_store[idx].amount;
                  if (sum > 24'hFFFFFF) sum = 24'hFFFFFF;
               end
               idx = ring_next(idx);
            end
            y.total = sum[TOTAL_W-1:0];
         end
         default: begin
         end
      endcase
      y.occupancy = fill_level[OCC_W-1:0];
      return y;
   endfunction

   task automatic push_item(input logic [ACT_W-1:0] action, input logic [KEY_W-1:0] key,
                            input logic [DAY_W-1:0] day, input logic [AMT_W-1:0] amount,
                            input logic [TKT_W-1:0] ticket);
      toll_req_type r;
      r.action = action;
      r.rec.key = key;
      r.rec.day = day;
      r.rec.amount = amount;
      r.rec.ticket = ticket;
      pending_reqs.push_back(r);
   endtask

   // Action mix depends on whether this stretch should fill, churn or drain the ring.
   task automatic push_random_item(input int seg_kind);
      int p_append, p_drop, p_read, p_find, p_sday, p_sall, r;
      logic [ACT_W-1:0] action;
      logic [KEY_W-1:0] key;
      logic [DAY_W-1:0] day;
      case (seg_kind)
         SEG_FILL: begin
            p_append = 70; p_drop = 10; p_read = 5; p_find = 6; p_sday = 4; p_sall = 3;
         end
         SEG_DRAIN: begin
            p_append = 15; p_drop = 55; p_read = 8; p_find = 10; p_sday = 5; p_sall = 5;
         end
         default: begin
            p_append = 35; p_drop = 30; p_read = 8; p_find = 12; p_sday = 6; p_sall = 6;
         end
      endcase
      r = $urandom_range(0, 99);
      if (r < p_append) action = ACT_APPEND;
      else if (r < p_append + p_drop) action = ACT_DROP;
      else if (r < p_append + p_drop + p_read) action = ACT_READ;
      else if (r < p_append + p_drop + p_read + p_find) action = ACT_FIND;
      else if (r < p_append + p_drop + p_read + p_find + p_sday) action = ACT_SUM_DAY;
      else if (r < p_append + p_drop + p_read + p_find + p_sday + p_sall) action = ACT_SUM_ALL;
      else action = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
      // Keys and days mostly come from small pools so finds hit and day sums match.
      key = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 15)]
                                        : {$urandom(), $urandom()};
      day = ($urandom_range(0, 9) < 7) ? day_pool[$urandom_range(0, 7)] : $urandom();
      push_item(action, key, day, AMT_W'($urandom_range(0, 65535)), $urandom());
   endtask

   task automatic wait_until_drained();
      do @(negedge clock);
      while (!(pending_reqs.size() == 0 && !req_tvalid && expected_replies.size() == 0));
   endtask

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(40, 200);
   endfunction

   // Request driver.
   toll_req_type current_req;
   int send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_replies.push_back(predict_reply(current_req));
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               current_req = pending_reqs.pop_front();
               req_tdata <= {current_req.rec.ticket, current_req.rec.amount,
                             current_req.rec.day, current_req.rec.key};
               req_tuser <= current_req.action;
               req_tvalid <= 1'b1;
               send_gap <= pick_gap((sent_count / 200) % 4 == 3);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and back-pressure.
   int stall_left = 0;
   bit hold_done = 1'b0;

   task automatic check_reply();
      toll_reply_type want;
      if (expected_replies.size() == 0) begin
         report_mismatch($sformatf("unexpected transaction, tdata %h", rsp_tdata));
         return;
      end
      want = expected_replies.pop_front();
      if (rsp_tuser != want.status)
         report_mismatch($sformatf("reply %0d status %0d, expected %0d",
                                   got_count, rsp_tuser, want.status));
      if (rsp_tdata[63:0] != want.rec.key)
         report_mismatch($sformatf("reply %0d found_key %h, expected %h",
                                   got_count, rsp_tdata[63:0], want.rec.key));
      if (rsp_tdata[95:64] != want.rec.day)
         report_mismatch($sformatf("reply %0d found_day %h, expected %h",
                                   got_count, rsp_tdata[95:64], want.rec.day));
      if (rsp_tdata[111:96] != want.rec.amount)
         report_mismatch($sformatf("reply %0d found_amount %h, expected %h",
                                   got_count, rsp_tdata[111:96], want.rec.amount));
      if (rsp_tdata[143:112] != want.rec.ticket)
         report_mismatch($sformatf("reply %0d found_ticket %h, expected %h",
                                   got_count, rsp_tdata[143:112], want.rec.ticket));
      if (rsp_tdata[167:144] != want.total)
         report_mismatch($sformatf("reply %0d total %h, expected %h",
                                   got_count, rsp_tdata[167:144], want.total));
      if (rsp_tdata[175:168] != want.occupancy)
         report_mismatch($sformatf("reply %0d occupancy %0d, expected %0d",
                                   got_count, rsp_tdata[175:168], want.occupancy));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_reply();
            got_count++;
         end
         // One long hold-off so the block backs up and stalls its request side.
         if (!hold_done && got_count >= HOLD_AT_COUNT) begin
            hold_done <= 1'b1;
            stall_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if ((got_count / 170) % 4 == 1 || $urandom_range(0, 99) < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                                      : $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [KEY_W-1:0] ones_key;
      logic [DAY_W-1:0] ones_day;
      logic [TKT_W-1:0] ones_tkt;
      ones_key = '1;
      ones_day = '1;
      ones_tkt = '1;
      foreach (key_pool[i]) key_pool[i] = {$urandom(), $urandom()};
      foreach (day_pool[i]) day_pool[i] = $urandom();

      // Every action but append on an empty ring, including the spare codes.
      push_item(ACT_READ, key_pool[0], day_pool[0], 16'd1, 32'd1);
      push_item(ACT_DROP, key_pool[0], day_pool[0], 16'd1, 32'd1);
      push_item(ACT_FIND, key_pool[0], day_pool[0], 16'd1, 32'd1);
      push_item(ACT_SUM_DAY, key_pool[0], day_pool[0], 16'd1, 32'd1);
      push_item(ACT_SUM_ALL, key_pool[0], day_pool[0], 16'd1, 32'd1);
      push_item(ACT_SPARE_LO, ones_key, ones_day, 16'hFFFF, ones_tkt);
      push_item(ACT_SPARE_HI, ones_key, ones_day, 16'hFFFF, ones_tkt);
      // Field extremes, then hits, misses and sums over them.
      push_item(ACT_APPEND, ones_key, ones_day, 16'hFFFF, ones_tkt);
      push_item(ACT_APPEND, '0, '0, '0, '0);
      push_item(ACT_APPEND, key_pool[0], day_pool[0], 16'd1234, 32'd77);
      push_item(ACT_READ, '0, '0, '0, '0);
      push_item(ACT_FIND, ones_key, '0, '0, '0);
      push_item(ACT_FIND, key_pool[0], '0, '0, '0);
      push_item(ACT_FIND, '0, '0, '0, '0);
      push_item(ACT_FIND, key_pool[5] ^ 64'h1, '0, '0, '0);
      push_item(ACT_SUM_DAY, '0, ones_day, '0, '0);
      push_item(ACT_SUM_DAY, '0, day_pool[0], '0, '0);
      push_item(ACT_SUM_DAY, '0, day_pool[3] ^ 32'h1, '0, '0);
      push_item(ACT_SUM_ALL, '0, '0, '0, '0);
      // A duplicate key: find must return the older record.
      push_item(ACT_APPEND, key_pool[0], day_pool[1], 16'd9, 32'd78);
      push_item(ACT_FIND, key_pool[0], '0, '0, '0);
      push_item(ACT_DROP, '0, '0, '0, '0);
      push_item(ACT_READ, '0, '0, '0, '0);
      push_item(ACT_SPARE_LO, '0, '0, '0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Sender pauses here until every reply of the directed part is back.
      wait_until_drained();

      // Fill three stretches, churn, drain three, churn, and repeat.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case ((n / SEG_LEN) % 8)
            0, 1, 2: push_random_item(SEG_FILL);
            4, 5, 6: push_random_item(SEG_DRAIN);
            default: push_random_item(SEG_MIXED);
         endcase
      end

      wait_until_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      while (expected_replies.size() > 0) begin
         void'(expected_replies.pop_front());
         report_mismatch("reply never arrived");
      end
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/krq_pkg.sv
rtl/krq_ctrl.sv
rtl/krq_dpath.sv
rtl/keyed_ring_queue.sv
verif/keyed_ring_queue_tb.sv
